// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; n2w_serial includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that masks it.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/n2w_pkg.sv =====
// ----------------------------------------------------------------------------
// n2w_pkg
// Types, word codes and phrase helpers for the number to word pipeline.
// ----------------------------------------------------------------------------
package n2w_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int DD_STAGES  = 4;
  localparam int DD_STEPS   = 8;
  localparam int MAX_WORDS  = 17;
  localparam int NUM_SEGS   = 5;
  localparam int SEG_WORDS  = 6;

  localparam logic [6:0] W_TENS      = 7'd20;
  localparam logic [6:0] W_ORD_UNITS = 7'd28;
  localparam logic [6:0] W_ORD_TENS  = 7'd48;
  localparam logic [6:0] W_HUNDRED   = 7'd56;
  localparam logic [6:0] W_THOUSAND  = 7'd57;
  localparam logic [6:0] W_MILLION   = 7'd58;
  localparam logic [6:0] W_BILLION   = 7'd59;
  localparam logic [6:0] W_ORD_OFF   = 7'd4;
  localparam logic [6:0] W_MINUS     = 7'd64;
  localparam logic [6:0] W_AND       = 7'd65;

  // Number on its way through the binary to decimal conversion.
  typedef struct packed {
    logic        ord;
    logic        neg;
    logic [4*NUM_DIGITS-1:0] bcd;
    logic [31:0] bin;
  } dd_t;

  typedef struct packed {
    logic [3:0][6:0] w;
    logic [2:0]      len;
  } cw_t;

  typedef struct packed {
    logic [SEG_WORDS-1:0][6:0] w;
    logic [2:0]                len;
  } seg_t;

  typedef struct packed {
    seg_t [NUM_SEGS-1:0] seg;
  } segs_t;

  typedef struct packed {
    logic [MAX_WORDS-1:0][6:0] w;
    logic [4:0]                cnt;
  } wbuf_t;

  // Words for a count below two thousand given as hundreds, tens and units.
  // The hundreds figure may run up to nineteen.
  function automatic cw_t count_words(input logic [4:0] h, input logic [3:0] t,
                                      input logic [3:0] u, input logic ord);
    cw_t        r;
    logic [2:0] n;
    logic       done;
    logic [6:0] val;
    r    = '0;
    n    = 3'd0;
    done = 1'b0;
    val  = (t == 4'd1) ? 7'd10 + 7'(u) : 7'(u);
    if (h != 5'd0) begin
      r.w[0] = 7'(h);
      if (t == 4'd0 && u == 4'd0) begin
        r.w[1] = ord ? W_HUNDRED + W_ORD_OFF : W_HUNDRED;
        n      = 3'd2;
        done   = 1'b1;
      end else begin
        r.w[1] = W_HUNDRED;
        n      = 3'd2;
      end
    end
    if (!done) begin
      if (t >= 4'd2) begin
        if (u == 4'd0) begin
          r.w[n[1:0]] = ord ? W_ORD_TENS + 7'(t) - 7'd2 : W_TENS + 7'(t) - 7'd2;
          n = n + 3'd1;
        end else begin
          r.w[n[1:0]] = W_TENS + 7'(t) - 7'd2;
          n = n + 3'd1;
          r.w[n[1:0]] = ord ? W_ORD_UNITS + 7'(u) : 7'(u);
          n = n + 3'd1;
        end
      end else begin
        r.w[n[1:0]] = ord ? W_ORD_UNITS + val : val;
        n = n + 3'd1;
      end
    end
    r.len = n;
    return r;
  endfunction

  // Count words followed by the group word and, where due, the and word.
  function automatic seg_t group_seg(input cw_t cw, input logic [6:0] gw,
                                     input logic rem_nz, input logic rem_small,
                                     input logic ord);
    seg_t       s;
    logic [2:0] i;
    s = '0;
    for (int k = 0; k < 4; k++) begin
      s.w[k] = cw.w[k];
    end
    i = cw.len;
    if (!rem_nz) begin
      s.w[i] = ord ? gw + W_ORD_OFF : gw;
      s.len  = i + 3'd1;
    end else begin
      s.w[i] = gw;
      if (rem_small) begin
        s.w[i + 3'd1] = W_AND;
        s.len = i + 3'd2;
      end else begin
        s.len = i + 3'd1;
      end
    end
    return s;
  endfunction

endpackage

// ===== design/number_to_word_tokens.sv =====
// ----------------------------------------------------------------------------
// number_to_word_tokens
// Speaks a signed 32-bit number as a run of English word codes.
// ----------------------------------------------------------------------------
// Latency: input register, 4 decimal stages, grouping, packing, serializer.
// Throughput: one word per cycle while out_stall is low; a number of N words
// (1 to 17) holds the serializer until its last word is sent, which sets the
// sustained item rate. The conversion pipeline (input, 4 decimal stages,
// grouping, packing) takes a new number every cycle while the serializer has
// room. Reset: synchronous, clears all valid bits and busy; data is not reset.
module number_to_word_tokens (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         word_code,
  output logic               last_word
);

  logic [31:0]  raw;
  logic         in_ready;
  logic [n2w_pkg::DD_STAGES:0] dv;
  logic [n2w_pkg::DD_STAGES:0] dr;
  n2w_pkg::dd_t dd [n2w_pkg::DD_STAGES+1];
  logic           wv, wr, pv, pr;
  n2w_pkg::segs_t wdata;
  n2w_pkg::wbuf_t pdata;

  assign raw      = value;
  assign in_ready = !dv[0] || dr[0];
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (in_ready) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dd[0].ord <= req_type;
      dd[0].neg <= raw[31];
      dd[0].bcd <= '0;
      dd[0].bin <= raw[31] ? ~raw + 32'd1 : raw;
    end
  end

  for (genvar s = 0; s < n2w_pkg::DD_STAGES; s++) begin : g_bcd
    n2w_bcd u_bcd (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[s]),
      .in_ready  (dr[s]),
      .in_data   (dd[s]),
      .out_valid (dv[s+1]),
      .out_ready (dr[s+1]),
      .out_data  (dd[s+1])
    );
  end

  n2w_words u_words (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv[n2w_pkg::DD_STAGES]),
    .in_ready  (dr[n2w_pkg::DD_STAGES]),
    .in_data   (dd[n2w_pkg::DD_STAGES]),
    .out_valid (wv),
    .out_ready (wr),
    .out_data  (wdata)
  );

  n2w_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wv),
    .in_ready  (wr),
    .in_data   (wdata),
    .out_valid (pv),
    .out_ready (pr),
    .out_data  (pdata)
  );

  n2w_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pv),
    .in_ready  (pr),
    .in_data   (pdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_code (word_code),
    .last_word (last_word)
  );

endmodule

// ===== design/n2w_bcd.sv =====
// ----------------------------------------------------------------------------
// n2w_bcd
// One stage of the shift and add-three binary to decimal conversion.
// ----------------------------------------------------------------------------
module n2w_bcd (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  n2w_pkg::dd_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output n2w_pkg::dd_t  out_data
);

  n2w_pkg::dd_t data_next;
  logic [4*n2w_pkg::NUM_DIGITS+31:0] sh;

  always_comb begin
    data_next = in_data;
    sh        = '0;
    for (int i = 0; i < n2w_pkg::DD_STEPS; i++) begin
      for (int k = 0; k < n2w_pkg::NUM_DIGITS; k++) begin
        if (data_next.bcd[4*k +: 4] >= 4'd5) begin
          data_next.bcd[4*k +: 4] = data_next.bcd[4*k +: 4] + 4'd3;
        end
      end
      sh = {data_next.bcd, data_next.bin} << 1;
      data_next.bcd = sh[4*n2w_pkg::NUM_DIGITS+31:32];
      data_next.bin = sh[31:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/n2w_words.sv =====
// ----------------------------------------------------------------------------
// n2w_words
// Splits the decimal digits into groups and builds the words of each group.
// ----------------------------------------------------------------------------
module n2w_words (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  n2w_pkg::dd_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output n2w_pkg::segs_t out_data
);

  n2w_pkg::segs_t data_next;
  n2w_pkg::cw_t   cw_last;
  logic [9:0][3:0] d;
  logic b_take, m_take, t_take, t_one;
  logic end_b, end_m, end_t;
  logic [4:0] h_final;

  always_comb begin
    for (int k = 0; k < n2w_pkg::NUM_DIGITS; k++) begin
      d[k] = in_data.bcd[4*k +: 4];
    end
    b_take = d[9] != 4'd0;
    m_take = in_data.bcd[35:24] != 12'd0;
    t_one  = in_data.bcd[23:12] == 12'd1;
    // Eleven hundred up to nineteen ninety-nine are said in hundreds.
    t_take = (in_data.bcd[23:12] != 12'd0) && !(t_one && d[2] != 4'd0);
    end_b  = b_take && (in_data.bcd[35:0] == 36'd0);
    end_m  = !end_b && m_take && (in_data.bcd[23:0] == 24'd0);
    end_t  = !end_b && !end_m && t_take && (in_data.bcd[11:0] == 12'd0);
    h_final = (t_one && !t_take) ? 5'd10 + 5'(d[2]) : 5'(d[2]);
    cw_last = n2w_pkg::count_words(h_final, d[1], d[0], in_data.ord);

    data_next = '0;
    data_next.seg[0].w[0] = n2w_pkg::W_MINUS;
    data_next.seg[0].len  = {2'b00, in_data.neg};
    if (b_take) begin
      data_next.seg[1] = n2w_pkg::group_seg(
          n2w_pkg::count_words(5'd0, 4'd0, d[9], 1'b0), n2w_pkg::W_BILLION,
          in_data.bcd[35:0] != 36'd0, in_data.bcd[35:8] == 28'd0, in_data.ord);
    end
    if (m_take && !end_b) begin
      data_next.seg[2] = n2w_pkg::group_seg(
          n2w_pkg::count_words(5'(d[8]), d[7], d[6], 1'b0), n2w_pkg::W_MILLION,
          in_data.bcd[23:0] != 24'd0, in_data.bcd[23:8] == 16'd0, in_data.ord);
    end
    if (t_take && !end_b && !end_m) begin
      data_next.seg[3] = n2w_pkg::group_seg(
          n2w_pkg::count_words(5'(d[5]), d[4], d[3], 1'b0), n2w_pkg::W_THOUSAND,
          in_data.bcd[11:0] != 12'd0, in_data.bcd[11:8] == 4'd0, in_data.ord);
    end
    if (!(end_b || end_m || end_t)) begin
      data_next.seg[4].w[3:0] = cw_last.w;
      data_next.seg[4].len    = cw_last.len;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/n2w_pack.sv =====
// ----------------------------------------------------------------------------
// n2w_pack
// Packs the group phrases into one contiguous word list with its length.
// ----------------------------------------------------------------------------
module n2w_pack (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  n2w_pkg::segs_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output n2w_pkg::wbuf_t out_data
);

  n2w_pkg::wbuf_t data_next;
  logic [n2w_pkg::NUM_SEGS:0][4:0] off;

  always_comb begin
    off[0] = 5'd0;
    for (int j = 0; j < n2w_pkg::NUM_SEGS; j++) begin
      off[j+1] = off[j] + 5'(in_data.seg[j].len);
    end
    data_next     = '0;
    data_next.cnt = off[n2w_pkg::NUM_SEGS];
    for (int j = 0; j < n2w_pkg::NUM_SEGS; j++) begin
      for (int w = 0; w < n2w_pkg::SEG_WORDS; w++) begin
        if (3'(w) < in_data.seg[j].len) begin
          data_next.w[5'(off[j] + 5'(w))] = in_data.seg[j].w[w];
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== design/n2w_serial.sv =====
// ----------------------------------------------------------------------------
// n2w_serial
// Sends the packed word list out one word per transfer and marks the last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module n2w_serial (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  n2w_pkg::wbuf_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [6:0]     word_code,
  output logic           last_word
);

  logic       busy;
  logic [4:0] idx;
  logic [4:0] cnt;
  logic [6:0] words [n2w_pkg::MAX_WORDS];
  logic       emit;
  logic       is_last;

  assign in_ready = !busy;
  assign emit     = busy && (!out_valid || !out_stall);
  assign is_last  = idx == cnt - 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy && in_valid) begin
        busy <= 1'b1;
      end else if (emit && is_last) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && in_valid) begin
      for (int k = 0; k < n2w_pkg::MAX_WORDS; k++) begin
        words[k] <= in_data.w[k];
      end
      cnt <= in_data.cnt;
      idx <= 5'd0;
    end else if (emit) begin
      idx <= idx + 5'd1;
    end
    if (emit) begin
      word_code <= words[idx];
      last_word <= is_last;
    end
  end

  `ASSERT_CLK(a_idx_range, clk, rst, busy |-> (idx < cnt), "Word index ran past the count.")
  `ASSERT_NEVER(a_cnt_bad, clk, rst, busy && (cnt == 5'd0 || cnt > 5'(n2w_pkg::MAX_WORDS)), "Bad word count.")
  `ASSERT_CLK(a_last_out, clk, rst, (emit && is_last) |=> (out_valid && last_word), "Last word not marked.")

endmodule

// ===== bench/number_to_word_tokens_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_tb
// Drives numbers in cardinal and ordinal mode into the word pipeline and
// compares every word code and end marker with a local speller.
// ----------------------------------------------------------------------------
module number_to_word_tokens_tb;

  typedef struct {
    logic [6:0] code;
    logic       last;
  } word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = 1'b0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [6:0]         word_code;
  logic               last_word;

  word_t      spoken_q[$];
  word_t      phrase[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         rx_wait = 0;
  int         rx_gap;
  bit         hold_off = 1'b0;
  bit         sending = 1'b1;

  number_to_word_tokens u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value), .out_valid(out_valid),
    .out_stall(out_stall), .word_code(word_code), .last_word(last_word)
  );

  always #4 clk = ~clk;

  function automatic void put(input logic [6:0] c);
    word_t w;
    w.code = c;
    w.last = 1'b0;
    phrase.push_back(w);
  endfunction

  function automatic void speak(input longint unsigned v, input bit ord);
    longint unsigned scale[3];
    logic [6:0]      gword[3];
    bit              take;
    int              t;
    scale = '{64'd1000000000, 64'd1000000, 64'd1000};
    gword = '{n2w_pkg::W_BILLION, n2w_pkg::W_MILLION, n2w_pkg::W_THOUSAND};
    for (int i = 0; i < 3; i++) begin
      if (i < 2) take = v >= scale[i];
      else take = (v >= 1000 && v <= 1099) || v >= 2000;
      if (take) begin
        speak(v / scale[i], 1'b0);
        v = v % scale[i];
        if (v == 0) begin
          put(ord ? gword[i] + n2w_pkg::W_ORD_OFF : gword[i]);
          return;
        end
        put(gword[i]);
        if (v < 100) put(n2w_pkg::W_AND);
      end
    end
    if (v >= 100) begin
      put(7'(v / 100));
      v = v % 100;
      if (v == 0) begin
        put(ord ? n2w_pkg::W_HUNDRED + n2w_pkg::W_ORD_OFF : n2w_pkg::W_HUNDRED);
        return;
      end
      put(n2w_pkg::W_HUNDRED);
    end
    if (v >= 20) begin
      t = int'((v - 20) / 10);
      if (v % 10 == 0) begin
        put(ord ? n2w_pkg::W_ORD_TENS + 7'(t) : n2w_pkg::W_TENS + 7'(t));
        return;
      end
      put(n2w_pkg::W_TENS + 7'(t));
      v = v % 10;
    end
    put(ord ? n2w_pkg::W_ORD_UNITS + 7'(v) : 7'(v));
  endfunction

  function automatic void predict_words(input bit ord, input logic [31:0] raw);
    longint unsigned mag;
    phrase.delete();
    if (raw[31]) begin
      put(n2w_pkg::W_MINUS);
      mag = 64'h1_0000_0000 - raw;
    end else begin
      mag = raw;
    end
    speak(mag, ord);
    phrase[phrase.size() - 1].last = 1'b1;
    foreach (phrase[k]) spoken_q.push_back(phrase[k]);
  endfunction

  // Valid stays high between back to back items and drops only for a gap.
  task automatic send_number(input bit ord, input logic [31:0] v, input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= ord;
    value    <= v;
    predict_words(ord, v);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (spoken_q.size() != 0) @(posedge clk);
  endtask

  // Output side: after each transfer it draws a random wait (rx_gap) and stalls
  // for it when nonzero, or holds off for a long stretch when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_gap = $urandom_range(0, 4);
      out_stall <= (rx_gap != 0);
      rx_wait   <= (rx_gap != 0) ? rx_gap - 1 : 0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Word checker: each transfer is compared with the oldest predicted word.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (spoken_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %0d last %0b", word_code, last_word);
      end else begin
        if (word_code !== spoken_q[0].code || last_word !== spoken_q[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %0d/%0b got %0d/%0b", spoken_q[0].code,
                     spoken_q[0].last, word_code, last_word);
        end
        void'(spoken_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || hold_off)
      idle_cycles <= 0;
    else if (sending || spoken_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{0, 1, 13, 19, 20, 21, 99, 100, 101, 110, 1000, 1001, 1099, 1100, 1999,
             2000, 2001, 1000000, 1000001, 1000000000, 1000000100, 32'h7FFFFFFF,
             32'h80000000, 32'hFFFFFFFF, 32'h8000_0001};
    foreach (vals[i]) send_number(i[0], vals[i]);
    foreach (vals[i]) send_number(!i[0], vals[i], 0);
  endtask

  task automatic test_random(input int n);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom_range(0, 120);
        1: v = $urandom_range(900, 2100);
        2: v = $urandom_range(0, 999) * 1000 + ($urandom_range(0, 1) ? $urandom_range(0, 99) : 0);
        3: v = -$urandom_range(0, 5000);
        default: v = $urandom();
      endcase
      send_number($urandom_range(0, 1), v, i % 40 < 30);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(20);
    join
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random(140);
    sending = 1'b0;
    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && spoken_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
